[hdl/mrs_pkg.sv]
// ----------------------------------------------------------------------------
// mrs_pkg: shared types and constants of the Modbus RTU register slave
// Transaction payloads, Modbus codes, storage sizes and the CRC-16 step.
// ----------------------------------------------------------------------------
package mrs_pkg;

    localparam int REG_COUNT   = 64;
    localparam int REG_AW      = $clog2(REG_COUNT);
    localparam int FRAME_BYTES = 256;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    localparam int MAX_READ_QTY  = 125;
    localparam int MAX_WRITE_QTY = 123;

    localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] CFG_GAP_TICKS  = 2'd1;

    typedef enum logic [1:0] {
        FUNC_RX_BYTE  = 2'd0,
        FUNC_TICK     = 2'd1,
        FUNC_TX_SLOT  = 2'd2,
        FUNC_LOCAL_WR = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  rx_byte;
        logic [5:0]  local_addr;
        logic [15:0] local_value;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] crc_error_count;
    } out_item_t;

    typedef struct packed {
        logic                en;
        logic [REG_AW-1:0]   addr;
        logic [15:0]         data;
    } reg_wr_t;

    typedef struct packed {
        logic                en;
        logic [FRAME_AW-1:0] addr;
        logic [7:0]          data;
    } rx_wr_t;

    // One byte of CRC-16/MODBUS, reflected polynomial.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/mrs_rx_ram.sv]
// ----------------------------------------------------------------------------
// mrs_rx_ram: frame byte store
// One write port and one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module mrs_rx_ram import mrs_pkg::*; (
    input  logic                aclk,
    input  rx_wr_t              wr,
    input  logic [FRAME_AW-1:0] rd_addr,
    output logic [7:0]          rd_data
);

    logic [7:0] mem [FRAME_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/mrs_reg_ram.sv]
// ----------------------------------------------------------------------------
// mrs_reg_ram: holding register file
// Registered-read memory with per-entry valid bits so that reset reads zero.
// ----------------------------------------------------------------------------
module mrs_reg_ram import mrs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  reg_wr_t           wr,
    input  logic [REG_AW-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0]          mem [REG_COUNT];
    logic [15:0]          rd_data_reg;
    logic [REG_COUNT-1:0] valid_reg;
    logic                 hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    assign rd_data = hit_reg ? rd_data_reg : 16'h0000;

endmodule

[hdl/modbus_rtu_register_slave.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave: Modbus RTU slave serving a 16-bit register file
// Frame collection, frame-end checking, register writes and reply generation.
// ----------------------------------------------------------------------------
// Usage: each input transaction on s_* carries one event: a received serial
// byte, a timer tick, a transmit slot, or a local register write. Every input
// transaction yields exactly one output transaction on m_*, which carries the
// transmit byte for a slot (tx_valid 0 when no reply is pending) and the
// current CRC error count.
// Flow: one item is worked on at a time. For a byte, a local write or a plain
// tick the result passes through the result state into the output register,
// and the next item is taken once the block is back in idle. A transmit slot
// adds a send state that reads the register file. A tick that ends a frame
// scans the frame store at one byte per cycle, then checks the frame, and for a
// write request scans the data bytes once more; both scans are bound by the
// single read port of the store. The output register lets the result wait;
// while m_ready is low the block can take one more item, then holds its result
// in the result state and accepts no further item.
// Reset (aresetn low, synchronous) clears all control state, returns the
// configuration to address 2 and a gap of 64000 ticks, and makes the whole
// register file read as zero at once. The frame store needs no clearing.
// Configuration writes on cfg_we are taken in any cycle.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave import mrs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EOF_SCAN,
        ST_EOF_CHECK,
        ST_WR_SCAN,
        ST_TX_SEND,
        ST_RESULT
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [7:0]  slave_addr_reg;
    logic [15:0] gap_ticks_reg;

    // Receive side.
    logic [FRAME_AW:0] rx_count_reg;
    logic [15:0]       gap_count_reg;
    logic              gap_running_reg;

    // Frame check.
    logic [FRAME_AW:0] n_reg;
    logic [FRAME_AW:0] scan_addr_reg;
    logic [FRAME_AW:0] scan_idx_reg;
    logic              scan_vld_reg;
    logic [15:0]       calc_crc_reg;
    logic [15:0]       got_crc_reg;
    logic [7:0]        hdr_reg [7];
    logic [7:0]        hi_byte_reg;
    logic [REG_AW-1:0] wr_ptr_reg;

    // Reply.
    logic        tx_active_reg;
    logic [7:0]  tx_length_reg;
    logic [7:0]  tx_pos_reg;
    logic [15:0] tx_crc_reg;
    logic [7:0]  reply_fn_reg;
    logic [15:0] reply_start_reg;
    logic [15:0] reply_qty_reg;
    logic [15:0] crc_errors_reg;

    // Pending result and output register.
    logic      res_valid_reg;
    logic [7:0] res_byte_reg;
    logic      res_last_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    // Memory ports.
    rx_wr_t              rx_wr;
    logic [FRAME_AW-1:0] rx_rd_addr;
    logic [7:0]          rx_rd_data;
    reg_wr_t             reg_wr;
    logic [REG_AW-1:0]   reg_rd_addr;
    logic [15:0]         reg_rd_data;

    logic        accept;
    logic [15:0] gap_next;
    logic [7:0]  tx_off;
    logic [15:0] start_w;
    logic [15:0] qty_w;
    logic [16:0] range_end;
    logic [9:0]  wr_frame_len;
    logic [7:0]  reply_b;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign gap_next     = gap_count_reg + 16'd1;
    assign tx_off       = tx_pos_reg - 8'd3;
    assign start_w      = {hdr_reg[2], hdr_reg[3]};
    assign qty_w        = {hdr_reg[4], hdr_reg[5]};
    assign range_end    = {1'b0, start_w} + {1'b0, qty_w};
    assign wr_frame_len = 10'd9 + {2'b00, hdr_reg[6]};

    // The frame store is read by the scan address; the register file by the
    // reply position on a transmit slot.
    assign rx_rd_addr  = scan_addr_reg[FRAME_AW-1:0];
    assign reg_rd_addr = reply_start_reg[REG_AW-1:0] + tx_off[REG_AW:1];

    always_comb begin
        rx_wr.en   = accept && (s_data.func == FUNC_RX_BYTE)
                     && (rx_count_reg < (FRAME_AW+1)'(FRAME_BYTES));
        rx_wr.addr = rx_count_reg[FRAME_AW-1:0];
        rx_wr.data = s_data.rx_byte;
    end

    always_comb begin
        reg_wr.en   = 1'b0;
        reg_wr.addr = s_data.local_addr[REG_AW-1:0];
        reg_wr.data = s_data.local_value;
        if (accept && (s_data.func == FUNC_LOCAL_WR)) begin
            reg_wr.en = 1'b1;
        end else if (state_reg == ST_WR_SCAN && scan_vld_reg && !scan_idx_reg[0]) begin
            reg_wr.en   = 1'b1;
            reg_wr.addr = wr_ptr_reg;
            reg_wr.data = {hi_byte_reg, rx_rd_data};
        end
    end

    // Reply byte for a position before the CRC.
    always_comb begin
        reply_b = 8'h00;
        if (tx_pos_reg == 8'd0) begin
            reply_b = slave_addr_reg;
        end else if (tx_pos_reg == 8'd1) begin
            reply_b = reply_fn_reg;
        end else if (reply_fn_reg == FC_WRITE_MULTI) begin
            priority case (tx_pos_reg)
                8'd2:    reply_b = reply_start_reg[15:8];
                8'd3:    reply_b = reply_start_reg[7:0];
                8'd4:    reply_b = reply_qty_reg[15:8];
                default: reply_b = reply_qty_reg[7:0];
            endcase
        end else if (tx_pos_reg == 8'd2) begin
            reply_b = {reply_qty_reg[6:0], 1'b0};
        end else begin
            reply_b = tx_off[0] ? reg_rd_data[7:0] : reg_rd_data[15:8];
        end
    end

    mrs_rx_ram u_rx_ram (
        .aclk    (aclk),
        .wr      (rx_wr),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    mrs_reg_ram u_reg_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (reg_wr),
        .rd_addr (reg_rd_addr),
        .rd_data (reg_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            slave_addr_reg  <= 8'd2;
            gap_ticks_reg   <= 16'd64000;
            rx_count_reg    <= '0;
            gap_count_reg   <= '0;
            gap_running_reg <= 1'b0;
            n_reg           <= '0;
            scan_addr_reg   <= '0;
            scan_idx_reg    <= '0;
            scan_vld_reg    <= 1'b0;
            tx_active_reg   <= 1'b0;
            tx_length_reg   <= '0;
            tx_pos_reg      <= '0;
            tx_crc_reg      <= CRC_INIT;
            reply_fn_reg    <= '0;
            reply_start_reg <= '0;
            reply_qty_reg   <= '0;
            crc_errors_reg  <= '0;
            res_valid_reg   <= 1'b0;
            res_last_reg    <= 1'b0;
            res_byte_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_SLAVE_ADDR) begin
                    slave_addr_reg <= cfg_wdata[7:0];
                end else if (cfg_index == CFG_GAP_TICKS) begin
                    gap_ticks_reg <= cfg_wdata;
                end
            end

            // In the result state the output register is handled below.
            if (m_valid_reg && m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    res_valid_reg <= 1'b0;
                    res_last_reg  <= 1'b0;
                    res_byte_reg  <= 8'h00;
                    if (accept) begin
                        state_reg <= ST_RESULT;
                        unique case (s_data.func)
                            FUNC_RX_BYTE: begin
                                if (rx_count_reg < (FRAME_AW+1)'(FRAME_BYTES)) begin
                                    rx_count_reg <= rx_count_reg + 1'b1;
                                end
                                gap_count_reg   <= '0;
                                gap_running_reg <= 1'b1;
                            end
                            FUNC_TICK: begin
                                if (gap_running_reg) begin
                                    if (gap_next >= gap_ticks_reg) begin
                                        gap_running_reg <= 1'b0;
                                        gap_count_reg   <= '0;
                                        if (rx_count_reg != '0) begin
                                            rx_count_reg <= '0;
                                            n_reg        <= rx_count_reg;
                                            if (!tx_active_reg && rx_count_reg >= 9'd4) begin
                                                state_reg     <= ST_EOF_SCAN;
                                                scan_addr_reg <= '0;
                                                scan_vld_reg  <= 1'b0;
                                                calc_crc_reg  <= CRC_INIT;
                                            end
                                        end
                                    end else begin
                                        gap_count_reg <= gap_next;
                                    end
                                end
                            end
                            FUNC_TX_SLOT: begin
                                if (tx_active_reg) begin
                                    state_reg <= ST_TX_SEND;
                                end
                            end
                            FUNC_LOCAL_WR: begin
                                // The register file write is issued combinationally.
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_EOF_SCAN: begin
                    if (scan_addr_reg < n_reg) begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                        scan_idx_reg  <= scan_addr_reg;
                        scan_vld_reg  <= 1'b1;
                    end else begin
                        scan_vld_reg <= 1'b0;
                    end
                    if (scan_vld_reg) begin
                        if (scan_idx_reg < n_reg - 9'd2) begin
                            calc_crc_reg <= crc_step(calc_crc_reg, rx_rd_data);
                        end
                        if (scan_idx_reg < 9'd7) begin
                            hdr_reg[scan_idx_reg[2:0]] <= rx_rd_data;
                        end
                        if (scan_idx_reg == n_reg - 9'd2) begin
                            got_crc_reg[7:0] <= rx_rd_data;
                        end
                        if (scan_idx_reg == n_reg - 9'd1) begin
                            got_crc_reg[15:8] <= rx_rd_data;
                            state_reg         <= ST_EOF_CHECK;
                        end
                    end
                end

                ST_EOF_CHECK: begin
                    state_reg <= ST_RESULT;
                    if (hdr_reg[0] == slave_addr_reg) begin
                        if (got_crc_reg != calc_crc_reg) begin
                            if (crc_errors_reg != 16'hFFFF) begin
                                crc_errors_reg <= crc_errors_reg + 16'd1;
                            end
                        end else if (hdr_reg[1] == FC_READ_HOLDING
                                     || hdr_reg[1] == FC_READ_INPUT) begin
                            if (n_reg == 9'd8 && qty_w != 16'd0
                                && qty_w <= 16'(MAX_READ_QTY)
                                && range_end <= 17'(REG_COUNT)) begin
                                reply_fn_reg    <= hdr_reg[1];
                                reply_start_reg <= start_w;
                                reply_qty_reg   <= qty_w;
                                tx_length_reg   <= 8'd3 + {qty_w[6:0], 1'b0};
                                tx_pos_reg      <= '0;
                                tx_crc_reg      <= CRC_INIT;
                                tx_active_reg   <= 1'b1;
                            end
                        end else if (hdr_reg[1] == FC_WRITE_MULTI) begin
                            if (n_reg >= 9'd9 && {1'b0, n_reg} == wr_frame_len
                                && qty_w != 16'd0 && qty_w <= 16'(MAX_WRITE_QTY)
                                && {9'd0, hdr_reg[6]} == {qty_w, 1'b0}
                                && range_end <= 17'(REG_COUNT)) begin
                                state_reg     <= ST_WR_SCAN;
                                scan_addr_reg <= 9'd7;
                                scan_vld_reg  <= 1'b0;
                                wr_ptr_reg    <= start_w[REG_AW-1:0];
                            end
                        end
                    end
                end

                ST_WR_SCAN: begin
                    if (scan_addr_reg < n_reg - 9'd2) begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                        scan_idx_reg  <= scan_addr_reg;
                        scan_vld_reg  <= 1'b1;
                    end else begin
                        scan_vld_reg <= 1'b0;
                    end
                    if (scan_vld_reg) begin
                        if (scan_idx_reg[0]) begin
                            hi_byte_reg <= rx_rd_data;
                        end else begin
                            wr_ptr_reg <= wr_ptr_reg + 1'b1;
                        end
                        if (scan_idx_reg == n_reg - 9'd3) begin
                            state_reg       <= ST_RESULT;
                            reply_fn_reg    <= FC_WRITE_MULTI;
                            reply_start_reg <= start_w;
                            reply_qty_reg   <= qty_w;
                            tx_length_reg   <= 8'd6;
                            tx_pos_reg      <= '0;
                            tx_crc_reg      <= CRC_INIT;
                            tx_active_reg   <= 1'b1;
                        end
                    end
                end

                ST_TX_SEND: begin
                    state_reg     <= ST_RESULT;
                    res_valid_reg <= 1'b1;
                    tx_pos_reg    <= tx_pos_reg + 8'd1;
                    if (tx_pos_reg < tx_length_reg) begin
                        res_byte_reg <= reply_b;
                        tx_crc_reg   <= crc_step(tx_crc_reg, reply_b);
                    end else if (tx_pos_reg == tx_length_reg) begin
                        res_byte_reg <= tx_crc_reg[7:0];
                    end else begin
                        res_byte_reg  <= tx_crc_reg[15:8];
                        res_last_reg  <= 1'b1;
                        tx_active_reg <= 1'b0;
                    end
                end

                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.tx_valid        <= res_valid_reg;
                        m_data_reg.tx_byte         <= res_byte_reg;
                        m_data_reg.tx_last         <= res_last_reg;
                        m_data_reg.crc_error_count <= crc_errors_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A final CRC byte is always a valid byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_last |-> m_data.tx_valid)
        else $error("tx_last without tx_valid");

    // The error counter only counts up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> crc_errors_reg >= $past(crc_errors_reg))
        else $error("crc error counter decreased");

    // The receive count never passes the frame store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= (FRAME_AW+1)'(FRAME_BYTES))
        else $error("receive count beyond frame store");

    // A reply never runs past its two CRC bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tx_active_reg |-> {1'b0, tx_pos_reg} <= {1'b0, tx_length_reg} + 9'd1)
        else $error("reply position beyond CRC");

endmodule
